>>> design/averaged_pid_servo_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Averaged PID servo controller: assertion macros
// Shared concurrent assertion forms for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_PID_SERVO_CONTROLLER_UNIT_DEFINES_SVH
`define AVERAGED_PID_SERVO_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define APSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define APSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/apsc_pkg.sv
// ----------------------------------------------------------------------------
// Averaged PID servo controller package
// Field widths, internal datapath widths, constants and register indexes.
// ----------------------------------------------------------------------------
package apsc_pkg;

  localparam int ANGLE_W   = 25;
  localparam int GAIN_W    = 16;
  localparam int WINDOW_W  = 24;
  localparam int COUNT_W   = 8;
  localparam int TIME_W    = 32;
  localparam int CMD_W     = 8;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 3;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int OUT_SHIFT       = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

  localparam int SUM_W   = 33;
  localparam int QMAG_W  = 32;
  localparam int ERR_W   = 33;
  localparam int DIFF_W  = 34;
  localparam int PROD_W  = 50;
  localparam int INTEG_W = 48;
  localparam int TOT_W   = 52;
  localparam int RQ_W    = TOT_W - OUT_SHIFT;

  localparam int DIVD_W  = 49;
  localparam int DIVS_W  = 23;
  localparam int MS_W    = 23;
  localparam int STEP_W  = 6;
  localparam int MCNT_W  = $clog2(GAIN_W + 1);

  localparam int SERVO_MID = 90;
  localparam int SERVO_MAX = 180;
  localparam int US_PER_MS = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_WINDOW = 3'd5;

  localparam logic [ANGLE_W-1:0]  RST_SETPOINT     = 25'd0;
  localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT = 8'd30;
  localparam logic [GAIN_W-1:0]   RST_GAIN_PROP    = 16'd1024;
  localparam logic [GAIN_W-1:0]   RST_GAIN_INTEG   = 16'd26;
  localparam logic [GAIN_W-1:0]   RST_GAIN_DERIV   = 16'd26;
  localparam logic [WINDOW_W-1:0] RST_INTEG_WINDOW = 24'd196608;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

>>> design/apsc_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned division, one quotient bit per cycle; the dividend arrives
// left-aligned and the step count sets how many bits are resolved.
// ----------------------------------------------------------------------------
module apsc_div
  import apsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0] q;
  logic [DIVS_W-1:0] r;
  logic [DIVS_W-1:0] d;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [DIVS_W:0]   r2;
  logic [DIVS_W:0]   r2_sub;
  logic              ge;

  always_comb begin
    r2     = {r, q[DIVD_W-1]};
    r2_sub = r2 - {1'b0, d};
    ge     = (r2 >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= {q[DIVD_W-2:0], ge};
      r <= ge ? r2_sub[DIVS_W-1:0] : r2[DIVS_W-1:0];
    end
  end

  assign quotient = q;

endmodule

>>> design/apsc_mul.sv
// ----------------------------------------------------------------------------
// Serial gain multiplier
// Unsigned gain times signed operand, one gain bit per cycle (shift and add).
// ----------------------------------------------------------------------------
module apsc_mul
  import apsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [GAIN_W-1:0] gain,
  input  logic [DIFF_W-1:0] multiplicand,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic [PROD_W-1:0] m;
  logic [GAIN_W-1:0] g;
  logic [PROD_W-1:0] acc;
  logic [MCNT_W-1:0] cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MCNT_W'(GAIN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m   <= {{(PROD_W-DIFF_W){multiplicand[DIFF_W-1]}}, multiplicand};
      g   <= gain;
      acc <= '0;
    end else if (busy) begin
      if (g[0]) begin
        acc <= acc + m;
      end
      m <= {m[PROD_W-2:0], 1'b0};
      g <= {1'b0, g[GAIN_W-1:1]};
    end
  end

  assign product = acc;

endmodule

>>> design/averaged_pid_servo_controller_unit.sv
// ----------------------------------------------------------------------------
// Averaged PID servo controller
// Each sample item is added to the running sum when it is accepted, and the
// block takes the next item at once. The item that completes a batch starts
// a control update, during which sample_stall is high; the update uses the
// shared bit-serial divider (32 steps for the average, 32 for the millisecond
// count, 49 for the derivative, which is skipped when the elapsed time is
// under one millisecond) and the bit-serial gain multiplier (16 steps for
// each of the three gains). A finished command waits in the output register
// while new samples are accepted; an update stalls at its end only if the
// previous command has not yet been taken.
// ----------------------------------------------------------------------------
`include "averaged_pid_servo_controller_unit_defines.svh"

module averaged_pid_servo_controller_unit
  import apsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic signed [ANGLE_W-1:0] angle_sample,
  input  logic [TIME_W-1:0]    timestamp_us,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [CMD_W-1:0]     servo_command,
  output logic                 saturated,
  output logic                 zero_elapsed
);

  typedef enum logic [4:0] {
    S_IDLE, S_AVG_GO, S_AVG_WAIT, S_ERR, S_MAG, S_ELAP_GO, S_ELAP_WAIT,
    S_IMUL_GO, S_IMUL_WAIT, S_PMUL_GO, S_PMUL_WAIT, S_DMUL_GO, S_DMUL_WAIT,
    S_DDIV_GO, S_DDIV_WAIT, S_ROUND, S_FINISH
  } state_t;

  state_t state;

  logic [ANGLE_W-1:0]  setpoint;
  logic [COUNT_W-1:0]  sample_count;
  logic [GAIN_W-1:0]   gain_prop;
  logic [GAIN_W-1:0]   gain_integ;
  logic [GAIN_W-1:0]   gain_deriv;
  logic [WINDOW_W-1:0] integ_window;

  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] sample_counter;
  logic [INTEG_W-1:0] integral_term;
  logic [ERR_W-1:0]   last_error;
  logic [TIME_W-1:0]  last_update_time;

  logic [TIME_W-1:0]  ts;
  logic [ERR_W-1:0]   avg;
  logic [ERR_W-1:0]   err;
  logic [ERR_W-1:0]   mag;
  logic [DIFF_W-1:0]  diff;
  logic [TIME_W-1:0]  elapsed;
  logic [MS_W-1:0]    ms;
  logic               zero_el;
  logic               in_window;
  logic [TOT_W-1:0]   total;
  logic               dneg;
  logic [DIVD_W-1:0]  dmag;
  logic [RQ_W-1:0]    rq;

  logic [COUNT_W-1:0] n_eff;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] counter_next;
  logic               batch_done;
  logic               sample_take;
  logic               out_free;
  logic [SUM_W-1:0]   sum_mag;
  logic [ERR_W-1:0]   sp_ext;
  logic [PROD_W-1:0]  isum;
  logic               isum_ovf;
  logic [INTEG_W-1:0] integ_sat;
  logic [PROD_W-1:0]  prod_abs;
  logic [TOT_W-1:0]   round_total;
  logic [RQ_W-1:0]    u;
  logic [CMD_W-1:0]   cmd;
  logic               cmd_sat;

  div_ctl_t           div_ctl;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIVD_W-1:0]  div_q;

  logic               mul_start;
  logic [GAIN_W-1:0]  mul_gain;
  logic [DIFF_W-1:0]  mul_a;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;

  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  always_comb begin
    n_eff        = (sample_count == '0) ? COUNT_W'(1) : sample_count;
    sum_next     = sample_sum
                 + {{(SUM_W-ANGLE_W){angle_sample[ANGLE_W-1]}}, angle_sample};
    counter_next = sample_counter + 1'b1;
    batch_done   = (counter_next >= n_eff);
    sum_mag      = sample_sum[SUM_W-1] ? -sample_sum : sample_sum;
    sp_ext       = {{(ERR_W-ANGLE_W){setpoint[ANGLE_W-1]}}, setpoint};
    isum         = {{(PROD_W-INTEG_W){integral_term[INTEG_W-1]}}, integral_term}
                 + mul_prod;
    isum_ovf     = !((&isum[PROD_W-1:INTEG_W-1]) || !(|isum[PROD_W-1:INTEG_W-1]));
    if (isum_ovf) begin
      integ_sat = isum[PROD_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                 : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
    prod_abs    = mul_prod[PROD_W-1] ? -mul_prod : mul_prod;
    round_total = total + (total[TOT_W-1] ? TOT_W'((64'd1 << OUT_SHIFT) - 64'd1)
                                          : TOT_W'(0));
    u           = rq + RQ_W'(SERVO_MID);
    if (u[RQ_W-1]) begin
      cmd     = '0;
      cmd_sat = 1'b1;
    end else if (u > RQ_W'(SERVO_MAX)) begin
      cmd     = CMD_W'(SERVO_MAX);
      cmd_sat = 1'b1;
    end else begin
      cmd     = u[CMD_W-1:0];
      cmd_sat = 1'b0;
    end
  end

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = '0;
    div_dividend  = '0;
    div_divisor   = '0;
    mul_start     = 1'b0;
    mul_gain      = '0;
    mul_a         = '0;
    case (state)
      S_AVG_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(QMAG_W);
        div_dividend  = {sum_mag[QMAG_W-1:0], {(DIVD_W-QMAG_W){1'b0}}};
        div_divisor   = {{(DIVS_W-COUNT_W){1'b0}}, n_eff};
      end
      S_ELAP_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(TIME_W);
        div_dividend  = {elapsed, {(DIVD_W-TIME_W){1'b0}}};
        div_divisor   = DIVS_W'(US_PER_MS);
      end
      S_DDIV_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(DIVD_W);
        div_dividend  = dmag;
        div_divisor   = ms;
      end
      S_IMUL_GO: begin
        mul_start = 1'b1;
        mul_gain  = gain_integ;
        mul_a     = {err[ERR_W-1], err};
      end
      S_PMUL_GO: begin
        mul_start = 1'b1;
        mul_gain  = gain_prop;
        mul_a     = {err[ERR_W-1], err};
      end
      S_DMUL_GO: begin
        mul_start = 1'b1;
        mul_gain  = gain_deriv;
        mul_a     = diff;
      end
      default: begin
      end
    endcase
  end

  apsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  apsc_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .gain         (mul_gain),
    .multiplicand (mul_a),
    .done         (mul_done),
    .product      (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= RST_SETPOINT;
      sample_count <= RST_SAMPLE_COUNT;
      gain_prop    <= RST_GAIN_PROP;
      gain_integ   <= RST_GAIN_INTEG;
      gain_deriv   <= RST_GAIN_DERIV;
      integ_window <= RST_INTEG_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:     setpoint     <= cfg_data[ANGLE_W-1:0];
        REG_SAMPLE_COUNT: sample_count <= cfg_data[COUNT_W-1:0];
        REG_GAIN_PROP:    gain_prop    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:   gain_integ   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:   gain_deriv   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_WINDOW: integ_window <= cfg_data[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_valid     <= 1'b0;
      sample_sum       <= '0;
      sample_counter   <= '0;
      integral_term    <= '0;
      last_error       <= '0;
      last_update_time <= '0;
    end else begin
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_take) begin
            sample_sum     <= sum_next;
            sample_counter <= counter_next;
            if (batch_done) begin
              state <= S_AVG_GO;
            end
          end
        end
        S_AVG_GO:  state <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (div_done) begin
            state <= S_ERR;
          end
        end
        S_ERR:     state <= S_MAG;
        S_MAG:     state <= S_ELAP_GO;
        S_ELAP_GO: state <= S_ELAP_WAIT;
        S_ELAP_WAIT: begin
          if (div_done) begin
            state <= S_IMUL_GO;
          end
        end
        S_IMUL_GO: state <= S_IMUL_WAIT;
        S_IMUL_WAIT: begin
          if (mul_done) begin
            if (in_window) begin
              integral_term <= integ_sat;
            end
            state <= S_PMUL_GO;
          end
        end
        S_PMUL_GO: state <= S_PMUL_WAIT;
        S_PMUL_WAIT: begin
          if (mul_done) begin
            state <= S_DMUL_GO;
          end
        end
        S_DMUL_GO: state <= S_DMUL_WAIT;
        S_DMUL_WAIT: begin
          if (mul_done) begin
            state <= zero_el ? S_ROUND : S_DDIV_GO;
          end
        end
        S_DDIV_GO: state <= S_DDIV_WAIT;
        S_DDIV_WAIT: begin
          if (div_done) begin
            state <= S_ROUND;
          end
        end
        S_ROUND:   state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            servo_command    <= cmd;
            saturated        <= cmd_sat;
            zero_elapsed     <= zero_el;
            result_valid     <= 1'b1;
            last_error       <= err;
            last_update_time <= ts;
            sample_sum       <= '0;
            sample_counter   <= '0;
            state            <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (sample_take) begin
          ts <= timestamp_us;
        end
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          avg <= sample_sum[SUM_W-1] ? -{1'b0, div_q[QMAG_W-1:0]}
                                     : {1'b0, div_q[QMAG_W-1:0]};
        end
      end
      S_ERR: begin
        err     <= avg - sp_ext;
        elapsed <= ts - last_update_time;
      end
      S_MAG: begin
        mag  <= err[ERR_W-1] ? -err : err;
        diff <= {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
      end
      S_ELAP_WAIT: begin
        if (div_done) begin
          ms      <= div_q[MS_W-1:0];
          zero_el <= (div_q[MS_W-1:0] == '0);
        end
      end
      S_IMUL_GO: begin
        in_window <= (mag < {{(ERR_W-WINDOW_W){1'b0}}, integ_window});
      end
      S_PMUL_WAIT: begin
        if (mul_done) begin
          total <= {{(TOT_W-PROD_W){mul_prod[PROD_W-1]}}, mul_prod}
                 + {{(TOT_W-INTEG_W){integral_term[INTEG_W-1]}}, integral_term};
        end
      end
      S_DMUL_WAIT: begin
        if (mul_done) begin
          dneg <= mul_prod[PROD_W-1];
          dmag <= prod_abs[DIVD_W-1:0];
        end
      end
      S_DDIV_WAIT: begin
        if (div_done) begin
          total <= dneg ? total - {{(TOT_W-DIVD_W){1'b0}}, div_q}
                        : total + {{(TOT_W-DIVD_W){1'b0}}, div_q};
        end
      end
      S_ROUND: begin
        rq <= round_total[TOT_W-1:OUT_SHIFT];
      end
      default: begin
      end
    endcase
  end

  `APSC_ASSERT_IMP(a_cmd_range, clk, rst, result_valid,
                   servo_command <= CMD_W'(SERVO_MAX), "servo command above range")
  `APSC_ASSERT_IMP(a_sat_edge, clk, rst, result_valid && saturated,
                   (servo_command == '0) || (servo_command == CMD_W'(SERVO_MAX)),
                   "saturated command not at a limit")
  `APSC_ASSERT_IMP(a_no_zero_div, clk, rst, state == S_DDIV_GO,
                   !zero_el && (ms != '0), "derivative divide by zero elapsed time")
  `APSC_ASSERT_NXT(a_finish_load, clk, rst, (state == S_FINISH) && out_free,
                   result_valid && (state == S_IDLE) && (sample_counter == '0),
                   "update did not complete cleanly")

endmodule
